/* rtl/jsu_pkg.sv */
`default_nettype none
package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_QUOTE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNTERM_STR = 3'd1;
  localparam logic [2:0] ERR_CTRL_CHAR  = 3'd2;
  localparam logic [2:0] ERR_UNTERM_ESC = 3'd3;
  localparam logic [2:0] ERR_BAD_ESC    = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd5;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] HI_SURR_LO = 16'hD800;
  localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LO_SURR_LO = 16'hDC00;
  localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
  localparam logic [20:0] CP_REPL    = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP    = 21'h010000;

  localparam int unsigned MAX_RES = 4;

  typedef enum logic [6:0] {
    MODE_NORMAL     = 7'b0000001,
    MODE_ESCAPE     = 7'b0000010,
    MODE_HEX_FIRST  = 7'b0000100,
    MODE_HIGH_HELD  = 7'b0001000,
    MODE_HIGH_SLASH = 7'b0010000,
    MODE_HEX_SECOND = 7'b0100000,
    MODE_DONE       = 7'b1000000
  } mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
  } res_t;

  // one request's worth of results
  typedef struct packed {
    logic                vld;
    logic [1:0]          last;
    res_t [MAX_RES-1:0]  res;
  } bun_t;

  typedef struct packed {
    logic  vld;
    res_t  res;
    mode_e mode;
  } step_t;

  typedef struct packed {
    logic [2:0]       n;
    logic [3:0][7:0]  b;
  } utf8_t;

  function automatic res_t mk_res(logic [7:0] data, logic [1:0] kind, logic [2:0] err);
    res_t r;
    r.data = data;
    r.kind = kind;
    r.err  = err;
    return r;
  endfunction

  function automatic step_t normal_byte(logic [7:0] b);
    step_t s;
    s.vld  = 1'b1;
    s.res  = mk_res(b, KIND_DATA, ERR_NONE);
    s.mode = MODE_NORMAL;
    if (b == CH_QUOTE) begin
      s.res  = mk_res(8'h00, KIND_QUOTE, ERR_NONE);
      s.mode = MODE_DONE;
    end else if (b < CH_SPACE) begin
      s.res  = mk_res(8'h00, KIND_ERROR, ERR_CTRL_CHAR);
      s.mode = MODE_DONE;
    end else if (b == CH_BSLASH) begin
      s.vld  = 1'b0;
      s.mode = MODE_ESCAPE;
    end
    return s;
  endfunction

  function automatic step_t escape_byte(logic [7:0] b);
    step_t s;
    s.vld  = 1'b1;
    s.mode = MODE_NORMAL;
    s.res  = mk_res(b, KIND_DATA, ERR_NONE);
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: s.res = mk_res(b, KIND_DATA, ERR_NONE);
      CH_B: s.res = mk_res(8'h08, KIND_DATA, ERR_NONE);
      CH_F: s.res = mk_res(8'h0C, KIND_DATA, ERR_NONE);
      CH_N: s.res = mk_res(8'h0A, KIND_DATA, ERR_NONE);
      CH_R: s.res = mk_res(8'h0D, KIND_DATA, ERR_NONE);
      CH_T: s.res = mk_res(8'h09, KIND_DATA, ERR_NONE);
      CH_U: begin
        s.vld  = 1'b0;
        s.mode = MODE_HEX_FIRST;
      end
      default: begin
        s.res  = mk_res(8'h00, KIND_ERROR, ERR_BAD_ESC);
        s.mode = MODE_DONE;
      end
    endcase
    return s;
  endfunction

  // 16 flags a non-hex byte
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [4:0] v;
    v = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
    return v;
  endfunction

  function automatic utf8_t utf8_enc(logic [20:0] cp);
    utf8_t u;
    u.b = '0;
    if (cp < 21'h80) begin
      u.n = 3'd1;
      u.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      u.n = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.n = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.n = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage
`default_nettype wire

/* rtl/jsu_decoder.sv */
`default_nettype none
// Escape decoder: mode state plus the per-request result bundle.
module jsu_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_text_i,
  output jsu_pkg::bun_t    bun_o
);

  jsu_pkg::mode_e  mode_q, mode_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [15:0]     acc_q, acc_d;
  logic [9:0]      held_q, held_d;

  logic            cp_en;
  logic [20:0]     cp;
  logic            tail_v;
  jsu_pkg::res_t   tail;
  jsu_pkg::step_t  st;
  jsu_pkg::utf8_t  enc;
  logic [4:0]      hv;
  logic [15:0]     unit;
  logic [2:0]      ncp;
  logic [2:0]      total;

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    held_d = held_q;
    cp_en  = 1'b0;
    cp     = jsu_pkg::CP_REPL;
    tail_v = 1'b0;
    tail   = '0;
    st     = '0;
    hv     = jsu_pkg::hex_value(in_byte_i);
    unit   = {acc_q[11:0], hv[3:0]};

    if (end_of_text_i) begin
      unique case (mode_q)
        jsu_pkg::MODE_NORMAL: begin
          tail_v = 1'b1;
          tail   = jsu_pkg::mk_res(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM_STR);
          mode_d = jsu_pkg::MODE_DONE;
        end
        jsu_pkg::MODE_ESCAPE: begin
          tail_v = 1'b1;
          tail   = jsu_pkg::mk_res(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM_ESC);
          mode_d = jsu_pkg::MODE_DONE;
        end
        jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_SECOND: begin
          tail_v = 1'b1;
          tail   = jsu_pkg::mk_res(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX);
          mode_d = jsu_pkg::MODE_DONE;
        end
        jsu_pkg::MODE_HIGH_HELD: begin
          cp_en  = 1'b1;
          tail_v = 1'b1;
          tail   = jsu_pkg::mk_res(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM_STR);
          mode_d = jsu_pkg::MODE_DONE;
        end
        jsu_pkg::MODE_HIGH_SLASH: begin
          cp_en  = 1'b1;
          tail_v = 1'b1;
          tail   = jsu_pkg::mk_res(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM_ESC);
          mode_d = jsu_pkg::MODE_DONE;
        end
        default: ;
      endcase
    end else begin
      unique case (mode_q)
        jsu_pkg::MODE_NORMAL: begin
          st     = jsu_pkg::normal_byte(in_byte_i);
          tail_v = st.vld;
          tail   = st.res;
          mode_d = st.mode;
        end
        jsu_pkg::MODE_ESCAPE: begin
          st     = jsu_pkg::escape_byte(in_byte_i);
          tail_v = st.vld;
          tail   = st.res;
          mode_d = st.mode;
          if (in_byte_i == jsu_pkg::CH_U) begin
            cnt_d = '0;
            acc_d = '0;
          end
        end
        jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_SECOND: begin
          if (hv[4]) begin
            tail_v = 1'b1;
            tail   = jsu_pkg::mk_res(8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX);
            mode_d = jsu_pkg::MODE_DONE;
          end else begin
            acc_d = unit;
            if (cnt_q != 2'd3) begin
              cnt_d = cnt_q + 2'd1;
            end else begin
              cnt_d = '0;
              if (mode_q == jsu_pkg::MODE_HEX_FIRST) begin
                if (unit >= jsu_pkg::HI_SURR_LO && unit <= jsu_pkg::HI_SURR_HI) begin
                  held_d = unit[9:0];
                  mode_d = jsu_pkg::MODE_HIGH_HELD;
                end else begin
                  cp_en  = 1'b1;
                  mode_d = jsu_pkg::MODE_NORMAL;
                  if (!(unit >= jsu_pkg::LO_SURR_LO && unit <= jsu_pkg::LO_SURR_HI)) begin
                    cp = {5'd0, unit};
                  end
                end
              end else begin
                cp_en  = 1'b1;
                mode_d = jsu_pkg::MODE_NORMAL;
                if (unit >= jsu_pkg::LO_SURR_LO && unit <= jsu_pkg::LO_SURR_HI) begin
                  cp = jsu_pkg::CP_SUPP + {1'b0, held_q, unit[9:0]};
                end
              end
            end
          end
        end
        jsu_pkg::MODE_HIGH_HELD: begin
          if (in_byte_i == jsu_pkg::CH_BSLASH) begin
            mode_d = jsu_pkg::MODE_HIGH_SLASH;
          end else begin
            cp_en  = 1'b1;
            st     = jsu_pkg::normal_byte(in_byte_i);
            tail_v = st.vld;
            tail   = st.res;
            mode_d = st.mode;
          end
        end
        jsu_pkg::MODE_HIGH_SLASH: begin
          if (in_byte_i == jsu_pkg::CH_U) begin
            mode_d = jsu_pkg::MODE_HEX_SECOND;
            cnt_d  = '0;
            acc_d  = '0;
          end else begin
            cp_en  = 1'b1;
            st     = jsu_pkg::escape_byte(in_byte_i);
            tail_v = st.vld;
            tail   = st.res;
            mode_d = st.mode;
          end
        end
        default: ;
      endcase
    end
  end

  // pack code point bytes, then the trailing result
  always_comb begin
    enc   = jsu_pkg::utf8_enc(cp);
    ncp   = cp_en ? enc.n : 3'd0;
    total = ncp + {2'b00, tail_v};
    bun_o.vld  = (total != 3'd0);
    bun_o.last = 2'(total - 3'd1);
    for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
      bun_o.res[i] = '0;
      if (3'(i) < ncp) begin
        bun_o.res[i] = jsu_pkg::mk_res(enc.b[i], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      end else if (tail_v && 3'(i) == ncp) begin
        bun_o.res[i] = tail;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_NORMAL;
      cnt_q  <= '0;
      acc_q  <= '0;
      held_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/jsu_out_buf.sv */
`default_nettype none
// Result register: holds one request's results and hands them out in order.
module jsu_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire jsu_pkg::bun_t  bun_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic [1:0]          kind_o,
  output logic [2:0]          error_code_o,
  output logic                last_o
);

  logic                               vld_q;
  logic [1:0]                         last_q;
  logic [1:0]                         idx_q;
  jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0] res_q;
  logic                               take;
  logic                               at_last;

  assign at_last      = (idx_q == last_q);
  assign take         = vld_q && out_ready_i;
  assign free_o       = !vld_q || (out_ready_i && at_last);
  assign out_valid_o  = vld_q;
  assign out_byte_o   = res_q[idx_q].data;
  assign kind_o       = res_q[idx_q].kind;
  assign error_code_o = res_q[idx_q].err;
  assign last_o       = at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      idx_q  <= '0;
      last_q <= '0;
    end else if (load_i && bun_i.vld) begin
      vld_q  <= 1'b1;
      idx_q  <= '0;
      last_q <= bun_i.last;
    end else if (take) begin
      if (at_last) vld_q <= 1'b0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && bun_i.vld) res_q <= bun_i.res;
  end

endmodule
`default_nettype wire

/* rtl/json_string_unescape_utf8.sv */
`default_nettype none
// JSON string body unescaper. Feed the bytes that follow the opening quote,
// one per request, and raise end_of_text_i on a final request when the text
// runs out. The block turns simple escapes and \uXXXX escapes (surrogate
// pairs joined, lone or broken surrogates replaced by U+FFFD) into UTF-8
// bytes. Each result carries kind_o (0 data, 1 closing quote, 2 error),
// error_code_o and last_o, which marks the final result of one input
// request; a request may give no result at all (a backslash, a hex digit).
// After a closing quote or an error every further request is taken and
// dropped until reset. Throughput: a request is taken every cycle while the
// output is ready and each gives at most one result; one that gives more
// (up to 4, from multi-byte UTF-8) holds the output register until all have
// left, one per cycle while ready. Results appear in the cycle after accept.
module json_string_unescape_utf8 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       kind_o,
  output logic [2:0]       error_code_o,
  output logic             last_o
);

  jsu_pkg::bun_t bun;
  logic          free;
  logic          accept;

  // New request can enter while the last result of the previous one leaves.
  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  jsu_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .bun_o         (bun)
  );

  jsu_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .bun_i        (bun),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

/* verif/json_string_unescape_utf8_tb.sv */
module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  // no progress on either channel for this many cycles ends the run
  localparam int STALL_LIMIT = 2000;

  // one decoded output: the fields of a result request plus its last flag
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] err;
    logic       last;
  } out_char_t;

  // ways the string can be brought to its one and only end
  typedef enum int {
    END_QUOTE,
    END_CTRL,
    END_EOT_PLAIN,
    END_EOT_ESC,
    END_BAD_ESC,
    END_EOT_HEX,
    END_BAD_HEX,
    END_HIGH_EOT,        // everything from here on starts with a held high surrogate
    END_HIGH_QUOTE,
    END_HIGH_CTRL,
    END_HIGH_SLASH_EOT,
    END_HIGH_BAD_ESC,
    END_HIGH_HEX_EOT,
    END_HIGH_BAD_HEX
  } text_end_e;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [7:0] in_byte_i     = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic [2:0] error_code_o;
  logic       last_o;

  // idle rates in percent, changed between phases
  int send_idle_pct = 32;
  int recv_idle_pct = 54;
  int sent_items    = 0;
  int fail_count    = 0;
  int stall_cycles  = 0;

  // decoder shadow state, reset values
  mode_e       dec_mode   = MODE_NORMAL;
  logic [1:0]  dec_digits = '0;
  logic [15:0] dec_unit   = '0;
  logic [9:0]  dec_high   = '0;

  out_char_t step_chars[$];     // results of the request being decoded
  out_char_t decoded_q[$];      // results still owed by the block

  logic [7:0] esc_chars [0:7] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                  CH_F, CH_N, CH_R, CH_T};

  json_string_unescape_utf8 u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow
  // ---------------------------------------------------------------------------

  function automatic void put(logic [7:0] d, logic [1:0] k, logic [2:0] e);
    out_char_t c;
    c.data = d;
    c.kind = k;
    c.err  = e;
    c.last = 1'b0;
    if (step_chars.size() < MAX_RES) step_chars.insert(step_chars.size(), c);
  endfunction

  function automatic void put_char(logic [7:0] d);
    put(d, KIND_DATA, ERR_NONE);
  endfunction

  // error result; the string is over after it
  function automatic void abort_text(logic [2:0] e);
    put(8'h00, KIND_ERROR, e);
    dec_mode = MODE_DONE;
  endfunction

  // UTF-8 encoding, one to four bytes
  function automatic void put_codepoint(logic [20:0] cp);
    if (cp < 21'h80) begin
      put_char(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_char(8'hC0 | {3'b000, cp[10:6]});
      put_char(8'h80 | {2'b00, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_char(8'hE0 | {4'b0000, cp[15:12]});
      put_char(8'h80 | {2'b00, cp[11:6]});
      put_char(8'h80 | {2'b00, cp[5:0]});
    end else begin
      put_char(8'hF0 | {5'b00000, cp[20:18]});
      put_char(8'h80 | {2'b00, cp[17:12]});
      put_char(8'h80 | {2'b00, cp[11:6]});
      put_char(8'h80 | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void take_plain(logic [7:0] b);
    if (b == CH_QUOTE) begin
      put(8'h00, KIND_QUOTE, ERR_NONE);
      dec_mode = MODE_DONE;
    end else if (b < CH_SPACE) begin
      abort_text(ERR_CTRL_CHAR);
    end else if (b == CH_BSLASH) begin
      dec_mode = MODE_ESCAPE;
    end else begin
      put_char(b);
    end
  endfunction

  function automatic void take_escape(logic [7:0] b);
    dec_mode = MODE_NORMAL;
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: put_char(b);
      CH_B: put_char(8'h08);
      CH_F: put_char(8'h0C);
      CH_N: put_char(8'h0A);
      CH_R: put_char(8'h0D);
      CH_T: put_char(8'h09);
      CH_U: begin
        dec_mode   = MODE_HEX_FIRST;
        dec_digits = '0;
        dec_unit   = '0;
      end
      default: abort_text(ERR_BAD_ESC);
    endcase
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] nibble_of(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
    if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 8'd10);
    if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 8'd10);
    return 5'h10;
  endfunction

  function automatic void take_hex(logic [7:0] b, logic second);
    logic [4:0] nib;
    nib = nibble_of(b);
    if (nib[4]) begin
      abort_text(ERR_BAD_HEX);
      return;
    end
    dec_unit = {dec_unit[11:0], nib[3:0]};
    if (dec_digits != 2'd3) begin
      dec_digits++;
      return;
    end
    dec_digits = '0;
    dec_mode   = MODE_NORMAL;
    if (second) begin
      // low unit completes the pair, anything else spoils it
      if (dec_unit >= LO_SURR_LO && dec_unit <= LO_SURR_HI)
        put_codepoint(CP_SUPP + 21'({dec_high, dec_unit[9:0]}));
      else
        put_codepoint(CP_REPL);
    end else if (dec_unit >= HI_SURR_LO && dec_unit <= HI_SURR_HI) begin
      dec_high = dec_unit[9:0];
      dec_mode = MODE_HIGH_HELD;
    end else if (dec_unit >= LO_SURR_LO && dec_unit <= LO_SURR_HI) begin
      put_codepoint(CP_REPL);     // low surrogate with no high before it
    end else begin
      put_codepoint({5'd0, dec_unit});
    end
  endfunction

  // decode one accepted request and queue the results it owes
  function automatic void unescape_step(logic [7:0] b, logic eot);
    step_chars.delete();
    if (eot) begin
      case (dec_mode)
        MODE_NORMAL:  abort_text(ERR_UNTERM_STR);
        MODE_ESCAPE:  abort_text(ERR_UNTERM_ESC);
        MODE_HEX_FIRST, MODE_HEX_SECOND: abort_text(ERR_BAD_HEX);
        MODE_HIGH_HELD: begin
          put_codepoint(CP_REPL);
          abort_text(ERR_UNTERM_STR);
        end
        MODE_HIGH_SLASH: begin
          put_codepoint(CP_REPL);
          abort_text(ERR_UNTERM_ESC);
        end
        default: ;
      endcase
    end else begin
      case (dec_mode)
        MODE_NORMAL:    take_plain(b);
        MODE_ESCAPE:    take_escape(b);
        MODE_HEX_FIRST: take_hex(b, 1'b0);
        MODE_HIGH_HELD: begin
          if (b == CH_BSLASH) begin
            dec_mode = MODE_HIGH_SLASH;
          end else begin
            // held high replaced by U+FFFD, byte then taken as a plain one
            put_codepoint(CP_REPL);
            dec_mode = MODE_NORMAL;
            take_plain(b);
          end
        end
        MODE_HIGH_SLASH: begin
          if (b == CH_U) begin
            dec_mode   = MODE_HEX_SECOND;
            dec_digits = '0;
            dec_unit   = '0;
          end else begin
            put_codepoint(CP_REPL);
            take_escape(b);
          end
        end
        MODE_HEX_SECOND: take_hex(b, 1'b1);
        default: ;
      endcase
    end
    if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
    foreach (step_chars[i]) decoded_q.insert(decoded_q.size(), step_chars[i]);
  endfunction

  function automatic void check_result();
    out_char_t want;
    if (decoded_q.size() == 0) begin
      $error("result with nothing expected: out_byte %h kind %0d error_code %0d last %0d",
             out_byte_o, kind_o, error_code_o, last_o);
      fail_count++;
      return;
    end
    want = decoded_q.pop_front();
    if (out_byte_o !== want.data) begin
      $error("out_byte: expected %h, got %h", want.data, out_byte_o);
      fail_count++;
    end
    if (kind_o !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, kind_o);
      fail_count++;
    end
    if (error_code_o !== want.err) begin
      $error("error_code: expected %0d, got %0d", want.err, error_code_o);
      fail_count++;
    end
    if (last_o !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, last_o);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: prediction on each accepted request, then the output check, so
  // the expectation is always queued before its result can be compared.
  // The receiver's ready is also driven here.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) unescape_step(in_byte_i, end_of_text_i);
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: any handshake counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("** json_string_unescape_utf8: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One request. Valid is only lowered when an idle gap comes first, so a
  // back-to-back request never sees valid dropped and raised in one step.
  task automatic send_req(input logic [7:0] b, input logic eot);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    sent_items++;
  endtask

  // hex digit, letters in random case
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) send_req(hex_char(4'($urandom)), 1'b0);
  endtask

  // \uXXXX for one 16-bit code unit
  task automatic send_unit(input logic [15:0] code_unit);
    send_req(CH_BSLASH, 1'b0);
    send_req(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_req(hex_char(code_unit[4*i +: 4]), 1'b0);
  endtask

  // any byte that stays plain text: no quote, backslash or control byte
  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [15:0] rand_high();
    return HI_SURR_LO | 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [15:0] rand_low();
    return LO_SURR_LO | 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    logic [4:0] nib;
    do begin
      b   = 8'($urandom);
      nib = nibble_of(b);
    end while (!nib[4]);
    return b;
  endfunction

  // byte that is no valid escape letter, control bytes included
  function automatic logic [7:0] rand_bad_escape();
    logic [7:0] b;
    logic       known;
    do begin
      b = 8'($urandom);
      known = (b == CH_U);
      foreach (esc_chars[i]) if (b == esc_chars[i]) known = 1'b1;
    end while (known);
    return b;
  endfunction

  // one well-formed piece of string text with random content
  task automatic send_random_token();
    int          roll;
    logic [15:0] code_unit;
    roll = $urandom_range(0, 19);
    if (roll < 8) begin
      send_req(rand_plain(), 1'b0);
    end else if (roll < 10) begin
      send_req(CH_BSLASH, 1'b0);
      send_req(esc_chars[$urandom_range(0, 7)], 1'b0);
    end else if (roll < 13) begin
      // BMP unit, spread over 1-, 2- and 3-byte encodings
      case ($urandom_range(0, 2))
        0:       code_unit = 16'($urandom_range(0, 16'h7F));
        1:       code_unit = 16'($urandom_range(16'h80, 16'h7FF));
        default: code_unit = 16'($urandom_range(16'h800, 16'hFFFF));
      endcase
      if (code_unit >= HI_SURR_LO && code_unit <= LO_SURR_HI) code_unit -= 16'h4000;
      send_unit(code_unit);
    end else if (roll < 14) begin
      send_unit(rand_low());                // lone low
    end else if (roll < 16) begin
      send_unit(rand_high());               // proper pair, four bytes out
      send_unit(rand_low());
    end else if (roll < 17) begin
      send_unit(rand_high());               // high then a non-low unit
      code_unit = 16'($urandom);
      if (code_unit >= LO_SURR_LO && code_unit <= LO_SURR_HI) code_unit ^= 16'h2000;
      send_unit(code_unit);
    end else if (roll < 18) begin
      send_unit(rand_high());               // high then plain text
      send_req(rand_plain(), 1'b0);
    end else begin
      send_unit(rand_high());               // high then a simple escape
      send_req(CH_BSLASH, 1'b0);
      send_req(esc_chars[$urandom_range(0, 7)], 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // plain byte extremes and every simple escape
  task automatic test_simple_escapes();
    send_req(CH_SPACE, 1'b0);
    send_req(8'hFF, 1'b0);
    send_text("\\\"\\\\\\/\\b\\f\\n\\r\\t");
  endtask

  // \u escapes: code point zero, top of range, broken surrogates
  task automatic test_unicode_escapes();
    send_unit(16'h0000);
    send_unit(16'hDBFF);                    // highest supplementary code point
    send_unit(16'hDFFF);
    send_unit(16'hDC00);                    // lone low
    send_unit(16'hD800);                    // high not followed by a backslash
    send_req(8'h78, 1'b0);
    send_unit(16'hD83D);                    // high, backslash, then no u
    send_text("\\t");
  endtask

  task automatic test_random_text(input int until_items);
    while (sent_items < until_items) send_random_token();
  endtask

  // The string can only end once per reset, so one ending is drawn at random.
  // A few requests follow that the block must swallow without results.
  task automatic test_termination();
    text_end_e how;
    how = text_end_e'($urandom_range(0, END_HIGH_BAD_HEX));
    if (how >= END_HIGH_EOT) send_unit(rand_high());
    case (how)
      END_QUOTE, END_HIGH_QUOTE:     send_req(CH_QUOTE, 1'b0);
      END_CTRL, END_HIGH_CTRL:       send_req(8'($urandom_range(0, 8'h1F)), 1'b0);
      END_EOT_PLAIN, END_HIGH_EOT:   send_req(8'($urandom), 1'b1);
      END_EOT_ESC, END_HIGH_SLASH_EOT: begin
        send_req(CH_BSLASH, 1'b0);
        send_req(8'($urandom), 1'b1);
      end
      END_BAD_ESC, END_HIGH_BAD_ESC: begin
        send_req(CH_BSLASH, 1'b0);
        send_req(rand_bad_escape(), 1'b0);
      end
      END_EOT_HEX, END_HIGH_HEX_EOT: begin
        send_req(CH_BSLASH, 1'b0);
        send_req(CH_U, 1'b0);
        send_digits($urandom_range(0, 3));
        send_req(8'($urandom), 1'b1);
      end
      default: begin                        // bad hex digit, first or second unit
        send_req(CH_BSLASH, 1'b0);
        send_req(CH_U, 1'b0);
        send_digits($urandom_range(0, 3));
        send_req(rand_non_hex(), 1'b0);
      end
    endcase
    send_req(8'($urandom), 1'b1);
    repeat (7) send_req(8'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles 32%, receiver 54%
    test_simple_escapes();
    test_unicode_escapes();
    test_random_text(110);

    // roles swapped
    send_idle_pct = 54;
    recv_idle_pct = 32;
    test_random_text(160);

    // full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(210);
    test_termination();
    in_valid_i <= 1'b0;

    // drain, then wait on to catch stray results
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** json_string_unescape_utf8: PASSED **");
    end else begin
      $display("** json_string_unescape_utf8: FAILED **");
    end
    $finish;
  end

endmodule
